/* rtl/bcat_pkg.sv */
// shared types, codes and constants of the block chain allocation table
`timescale 1ns / 1ps

package bcat_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned BLK_W  = 10;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RST     = 11'd1024;
  localparam logic [CNT_W-1:0] RESERVED_BLOCKS_RST = 11'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_ALLOC_NEXT = 3'd1,
    OP_FIND_NEXT  = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_FORMAT     = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_END   = 2'd1,
    ST_FREE  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_BLOCK_COUNT     = 1'b0,
    REG_RESERVED_BLOCKS = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    RD_BLK = 2'd0,
    RD_PTR = 2'd1,
    RD_CUR = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_LINK = 2'd1,
    RES_GOT  = 2'd2
  } res_sel_e;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_INIT     = 10'b0000000010,
    S_DECODE   = 10'b0000000100,
    S_LOOK     = 10'b0000001000,
    S_SCAN_RD  = 10'b0000010000,
    S_SCAN_CHK = 10'b0000100000,
    S_LINK     = 10'b0001000000,
    S_CLR_RD   = 10'b0010000000,
    S_CLR_CHK  = 10'b0100000000,
    S_FMT      = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] block;
  } in_t;

  typedef struct packed {
    logic [BLK_W-1:0] result_block;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] free_count;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] block_count;
    logic [CNT_W-1:0] reserved_blocks;
  } cfg_t;

  typedef struct packed {
    logic     latch_in;
    rd_sel_e  rd_sel;
    logic     scan_start;
    logic     ptr_inc;
    logic     claim;
    logic     link_wr;
    logic     clr_start;
    logic     clr_step;
    logic     fmt_start;
    logic     fmt_step;
    logic     fmt_finish;
    logic     res_load;
    res_sel_e res_sel;
    status_e  res_st;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            blk_oor;
    logic            ptr_end;
    logic            entry_free;
    logic            entry_end;
    logic            clr_last;
    logic            sweep_last;
  } sts_t;

endpackage

/* rtl/bcat_regs.sv */
// configuration registers behind the apb port
`timescale 1ns / 1ps

module bcat_regs import bcat_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  reg_e reg_idx;
  logic wr_en;

  assign reg_idx = reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_count     <= BLOCK_COUNT_RST;
      cfg_q.reserved_blocks <= RESERVED_BLOCKS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BLOCK_COUNT:     cfg_q.block_count     <= pwdata[CNT_W-1:0];
        REG_RESERVED_BLOCKS: cfg_q.reserved_blocks <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_COUNT:     prdata = DATA_W'(cfg_q.block_count);
      REG_RESERVED_BLOCKS: prdata = DATA_W'(cfg_q.reserved_blocks);
      default:             prdata = '0;
    endcase
  end

endmodule

/* rtl/bcat_ctrl.sv */
// controller state machine sequencing table operations
`timescale 1ns / 1ps

module bcat_ctrl import bcat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   link_pend_q, link_pend_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel  = RD_BLK;
    cmd_o.res_sel = RES_ZERO;
    cmd_o.res_st  = ST_OK;
    in_ready_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_INIT: begin
        cmd_o.rd_sel   = RD_PTR;
        cmd_o.fmt_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_DECODE: begin
        cmd_o.rd_sel = RD_BLK;
        unique case (sts_i.op)
          OP_ALLOC: begin
            cmd_o.scan_start = 1'b1;
            state_d = S_SCAN_RD;
          end
          OP_ALLOC_NEXT, OP_FIND_NEXT, OP_CLEAR: begin
            cmd_o.clr_start = 1'b1;
            if (sts_i.blk_oor) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_st   = ST_RANGE;
              state_d = S_LINK;
            end else begin
              state_d = S_LOOK;
            end
          end
          OP_FORMAT: begin
            cmd_o.fmt_start = 1'b1;
            state_d = S_FMT;
          end
          default: begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_st   = ST_RANGE;
            state_d = S_LINK;
          end
        endcase
      end
      S_LOOK: begin
        cmd_o.rd_sel = RD_BLK;
        if (sts_i.entry_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_st   = ST_FREE;
          state_d = S_LINK;
        end else begin
          unique case (sts_i.op)
            OP_FIND_NEXT: begin
              cmd_o.res_load = 1'b1;
              if (sts_i.entry_end) begin
                cmd_o.res_st = ST_END;
              end else begin
                cmd_o.res_sel = RES_LINK;
              end
              state_d = S_LINK;
            end
            OP_ALLOC_NEXT: begin
              if (sts_i.entry_end) begin
                cmd_o.scan_start = 1'b1;
                state_d = S_SCAN_RD;
              end else begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_sel  = RES_LINK;
                state_d = S_LINK;
              end
            end
            OP_CLEAR: begin
              state_d = S_CLR_RD;
            end
            default: begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_st   = ST_RANGE;
              state_d = S_LINK;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        cmd_o.rd_sel = RD_PTR;
        if (sts_i.ptr_end) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_st   = ST_END;
          state_d = S_LINK;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd_o.rd_sel = RD_PTR;
        if (sts_i.entry_free) begin
          cmd_o.claim    = 1'b1;
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_GOT;
          state_d = S_LINK;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_LINK: begin
        // finished: write the new link for allocate next, then hand off the result
        if (link_pend_q) begin
          cmd_o.link_wr = 1'b1;
        end
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_CLR_RD: begin
        cmd_o.rd_sel = RD_CUR;
        state_d = S_CLR_CHK;
      end
      S_CLR_CHK: begin
        cmd_o.rd_sel = RD_CUR;
        if (sts_i.entry_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_LINK;
        end else begin
          cmd_o.clr_step = 1'b1;
          if (sts_i.entry_end || sts_i.clr_last) begin
            cmd_o.res_load = 1'b1;
            state_d = S_LINK;
          end else begin
            state_d = S_CLR_RD;
          end
        end
      end
      S_FMT: begin
        cmd_o.rd_sel   = RD_PTR;
        cmd_o.fmt_step = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.fmt_finish = 1'b1;
          cmd_o.res_load   = 1'b1;
          state_d = S_LINK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;
  assign link_pend_d = (cmd_o.claim & (sts_i.op == OP_ALLOC_NEXT))
                     | (link_pend_q & ~cmd_o.link_wr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      link_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      link_pend_q <= link_pend_d;
    end
  end

endmodule

/* rtl/bcat_datapath.sv */
// link table memory, pointers, free count and result registers
`timescale 1ns / 1ps

module bcat_datapath import bcat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  in_t  in_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output out_t out_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW = $clog2(TABLE_DEPTH + 2);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = (EW > CNT_W) ? EW : CNT_W;
  localparam logic [EW-1:0] LinkEnd  = EW'(TABLE_DEPTH);
  localparam logic [EW-1:0] LinkFree = EW'(TABLE_DEPTH + 1);

  logic [EW-1:0]    mem [TABLE_DEPTH];
  logic [EW-1:0]    rdata_q;
  logic [OP_W-1:0]  op_q;
  logic [BLK_W-1:0] blk_q;
  logic [CW-1:0]    ptr_q;
  logic [CW-1:0]    hint_q;
  logic [CW-1:0]    free_q;
  logic [CW-1:0]    fmt_r_q;
  logic [CW-1:0]    steps_q;
  logic [IW-1:0]    cur_q;
  logic [BLK_W-1:0] res_q;
  status_e          st_q;
  out_t             out_q;

  logic [CW-1:0]    n_eff;
  logic [CW-1:0]    r_eff;
  logic [CW-1:0]    steps_inc;
  logic [IW-1:0]    blk_idx;
  logic [IW-1:0]    ptr_idx;
  logic [IW-1:0]    raddr;
  logic [IW-1:0]    waddr;
  logic [EW-1:0]    wdata;
  logic             we;
  logic [BLK_W-1:0] res_val;
  logic [XW-1:0]    free_x;

  assign n_eff = (XW'(cfg_i.block_count) > XW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : CW'(cfg_i.block_count);
  assign r_eff = (XW'(cfg_i.reserved_blocks) > XW'(n_eff)) ? n_eff
                                                           : CW'(cfg_i.reserved_blocks);
  assign steps_inc = CW'(steps_q + 1'b1);
  assign blk_idx   = IW'(blk_q);
  assign ptr_idx   = IW'(ptr_q);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_BLK:  raddr = blk_idx;
      RD_PTR:  raddr = ptr_idx;
      RD_CUR:  raddr = cur_q;
      default: raddr = blk_idx;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_idx;
    wdata = LinkEnd;
    priority if (cmd_i.claim) begin
      we    = 1'b1;
      waddr = ptr_idx;
      wdata = LinkEnd;
    end else if (cmd_i.link_wr) begin
      we    = 1'b1;
      waddr = blk_idx;
      wdata = EW'(ptr_q);
    end else if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = cur_q;
      wdata = LinkFree;
    end else if (cmd_i.fmt_step) begin
      we    = 1'b1;
      waddr = ptr_idx;
      wdata = (ptr_q < fmt_r_q) ? LinkEnd : LinkFree;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      hint_q  <= CW'(1);
      free_q  <= CW'(TABLE_DEPTH - 1);
      fmt_r_q <= CW'(1);
    end else begin
      priority if (cmd_i.scan_start) begin
        ptr_q <= hint_q;
      end else if (cmd_i.fmt_start) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc || cmd_i.fmt_step) begin
        ptr_q <= CW'(ptr_q + 1'b1);
      end

      priority if (cmd_i.claim) begin
        hint_q <= CW'(ptr_q + 1'b1);
        free_q <= (free_q == '0) ? '0 : CW'(free_q - 1'b1);
      end else if (cmd_i.clr_step) begin
        hint_q <= (CW'(cur_q) < hint_q) ? CW'(cur_q) : hint_q;
        free_q <= CW'(free_q + 1'b1);
      end else if (cmd_i.fmt_finish) begin
        hint_q <= fmt_r_q;
        free_q <= CW'(n_eff - fmt_r_q);
      end

      if (cmd_i.fmt_start) begin
        fmt_r_q <= r_eff;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.res_sel)
      RES_ZERO: res_val = '0;
      RES_LINK: res_val = BLK_W'(rdata_q);
      RES_GOT:  res_val = BLK_W'(ptr_q);
      default:  res_val = '0;
    endcase
  end

  assign free_x = XW'(free_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= in_i.op;
      blk_q <= in_i.block;
    end
    if (cmd_i.clr_start) begin
      cur_q   <= blk_idx;
      steps_q <= '0;
    end else if (cmd_i.clr_step) begin
      cur_q   <= rdata_q[IW-1:0];
      steps_q <= steps_inc;
    end
    if (cmd_i.res_load) begin
      res_q <= res_val;
      st_q  <= cmd_i.res_st;
    end
    if (cmd_i.out_load) begin
      out_q.result_block <= res_q;
      out_q.status       <= st_q;
      out_q.free_count   <= free_x[CNT_W-1:0];
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.blk_oor    = XW'(blk_q) >= XW'(n_eff);
  assign sts_o.ptr_end    = ptr_q >= n_eff;
  assign sts_o.entry_free = rdata_q == LinkFree;
  assign sts_o.entry_end  = rdata_q == LinkEnd;
  assign sts_o.clr_last   = (steps_inc == n_eff) || (XW'(rdata_q) >= XW'(n_eff));
  assign sts_o.sweep_last = ptr_q == CW'(TABLE_DEPTH - 1);

  assign out_o = out_q;

endmodule

/* rtl/block_chain_allocation_table_unit.sv */
// Block chain allocation table: one next-block link per disk block, each a block number,
// an end-of-chain mark or a free mark, held in a table with one write port and a registered
// read port, driven by a controller. After reset the table is initialized by a sweep over
// all TABLE_DEPTH entries (entry zero end, all others free) during which in_ready_o stays
// low; configuration writes are taken throughout. Find next reads the given entry; allocate
// scans entries from a lowest-possibly-free hint; allocate next adds a link write when the
// entry ends a chain; clear frees the chain entry by entry; format sweeps the whole table.
// Results sit in an output register, so the next transfer is taken while a result waits.
// free_count tracks a running count that only allocate, allocate next, clear and format
// update.
`timescale 1ns / 1ps

module block_chain_allocation_table_unit import bcat_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_t               in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  bcat_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bcat_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.claim, cmd.link_wr, cmd.clr_step, cmd.fmt_step}))
    else $error("more than one table write in a cycle");

  a_claim_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.claim |-> (!sts.ptr_end && sts.entry_free))
    else $error("claim of a block that is not free or beyond the count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before transfer");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !cmd.out_load)
    else $error("result loaded in the cycle after an input transfer");

endmodule

/* bench/block_chain_allocation_table_unit_tb.sv */
// self-checking testbench for the block chain allocation table unit
`timescale 1ns / 1ps

module block_chain_allocation_table_unit_tb;
  import bcat_pkg::*;

  localparam int unsigned NB          = TABLE_DEPTH_DEF;
  localparam logic [CNT_W-1:0] LINK_END  = CNT_W'(NB);
  localparam logic [CNT_W-1:0] LINK_FREE = CNT_W'(NB + 1);
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 180;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned OP_SPACE    = 2 ** OP_W;

  class chain_table_checker;
    logic [CNT_W-1:0] links [NB];
    int unsigned free_total;
    int unsigned blk_count;
    int unsigned rsv_blocks;
    out_t expected_replies [$];
    int unsigned failures;
    int unsigned replies_seen;

    function new();
      for (int unsigned i = 0; i < NB; i++) links[i] = LINK_FREE;
      links[0] = LINK_END;
      free_total = NB - 1;
      blk_count = BLOCK_COUNT_RST;
      rsv_blocks = RESERVED_BLOCKS_RST;
      failures = 0;
      replies_seen = 0;
    endfunction

    function void set_register(reg_e idx, int unsigned value);
      case (idx)
        REG_BLOCK_COUNT:     blk_count = value & ((1 << CNT_W) - 1);
        REG_RESERVED_BLOCKS: rsv_blocks = value & ((1 << CNT_W) - 1);
        default: ;
      endcase
    endfunction

    function int unsigned eff_count();
      return (blk_count > NB) ? NB : blk_count;
    endfunction

    function bit claim_lowest(output int unsigned got);
      int unsigned n;
      n = eff_count();
      got = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (links[i] == LINK_FREE) begin
          links[i] = LINK_END;
          if (free_total > 0) free_total--;
          got = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(in_t req);
      out_t exp;
      int unsigned n, got, cur, res, r;
      logic [CNT_W-1:0] v;
      status_e st;
      n = eff_count();
      res = 0;
      st = ST_OK;
      case (req.op)
        OP_ALLOC: begin
          if (claim_lowest(got)) res = got;
          else st = ST_END;
        end
        OP_ALLOC_NEXT, OP_FIND_NEXT, OP_CLEAR: begin
          if (req.block >= n) begin
            st = ST_RANGE;
          end else begin
            v = links[req.block];
            if (v == LINK_FREE) begin
              st = ST_FREE;
            end else if (req.op == OP_ALLOC_NEXT) begin
              if (v != LINK_END) begin
                res = v;
              end else if (claim_lowest(got)) begin
                links[req.block] = CNT_W'(got);
                res = got;
              end else begin
                st = ST_END;
              end
            end else if (req.op == OP_FIND_NEXT) begin
              if (v != LINK_END) res = v;
              else st = ST_END;
            end else begin
              cur = req.block;
              for (int unsigned i = 0; i < n; i++) begin
                if (cur >= n) break;
                v = links[cur];
                if (v == LINK_FREE) break;
                links[cur] = LINK_FREE;
                free_total++;
                if (v == LINK_END) break;
                cur = v;
              end
            end
          end
        end
        OP_FORMAT: begin
          r = (rsv_blocks > n) ? n : rsv_blocks;
          for (int unsigned i = 0; i < NB; i++) links[i] = (i < r) ? LINK_END : LINK_FREE;
          free_total = n - r;
        end
        default: st = ST_RANGE;
      endcase
      exp.result_block = res[BLK_W-1:0];
      exp.status = st;
      exp.free_count = free_total[CNT_W-1:0];
      expected_replies.push_back(exp);
    endfunction

    function void check_reply(out_t got);
      out_t exp;
      replies_seen++;
      if (expected_replies.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("reply %0d unexpected: block %0d status %0d free %0d", replies_seen,
                   got.result_block, got.status, got.free_count);
        return;
      end
      exp = expected_replies.pop_front();
      if (got.result_block !== exp.result_block || got.status !== exp.status ||
          got.free_count !== exp.free_count) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("reply %0d mismatch (exp/got): block %0d/%0d status %0d/%0d free %0d/%0d",
                   replies_seen, exp.result_block, got.result_block, exp.status, got.status,
                   exp.free_count, got.free_count);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  in_t               in_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_t              out_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  chain_table_checker sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_kick;
  int unsigned quiet_cycles = 0;

  int unsigned bc_plan  [PHASES] = '{16, 1024, 2047, 1, 0, 100, 1024, 37, 512, 1024};
  int unsigned rsv_plan [PHASES] = '{2, 0, 1024, 2047, 0, 7, 1, 40, 3, 1};

  block_chain_allocation_table_unit #(.TABLE_DEPTH(NB)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side, with an occasional long hold-off
  initial begin
    int unsigned hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_kick != hold_seen) begin
        hold_seen = hold_kick;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_reply(out_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic in_t mk(logic [OP_W-1:0] op, int unsigned blk);
    in_t req;
    req.op = op;
    req.block = BLK_W'(blk);
    return req;
  endfunction

  function automatic in_t make_request();
    in_t req;
    int unsigned pick, n, cand;
    n = sb.eff_count();
    pick = $urandom_range(999);
    if (pick < 250) req.op = OP_ALLOC;
    else if (pick < 550) req.op = OP_ALLOC_NEXT;
    else if (pick < 780) req.op = OP_FIND_NEXT;
    else if (pick < 950) req.op = OP_CLEAR;
    else if (pick < 965) req.op = OP_FORMAT;
    else req.op = OP_W'($urandom_range(OP_SPACE - 1, int'(OP_FORMAT) + 1));
    req.block = BLK_W'($urandom_range(NB - 1));
    pick = $urandom_range(99);
    if (pick < 55 && n > 0) begin
      for (int k = 0; k < 8; k++) begin
        cand = $urandom_range(n - 1);
        if (sb.links[cand] != LINK_FREE) begin
          req.block = cand[BLK_W-1:0];
          break;
        end
      end
    end else if (pick < 80 && n > 0) begin
      req.block = BLK_W'($urandom_range(n - 1));
    end
    return req;
  endfunction

  task automatic send_op(input in_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_i = req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input int unsigned value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(int'(idx) * 4);
    pwdata = DATA_W'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    int unsigned mode;
    sb = new();
    hold_kick = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_op(mk(OP_FIND_NEXT, 0));
    send_op(mk(OP_FIND_NEXT, 1));
    send_op(mk(OP_FIND_NEXT, NB - 1));
    send_op(mk(OP_ALLOC, 0));
    send_op(mk(OP_ALLOC_NEXT, 1));
    send_op(mk(OP_ALLOC_NEXT, 1));
    send_op(mk(OP_FIND_NEXT, 1));
    send_op(mk(OP_ALLOC_NEXT, 2));
    send_op(mk(OP_ALLOC_NEXT, 700));
    send_op(mk(OP_CLEAR, 1));
    send_op(mk(OP_CLEAR, 1));
    for (int k = int'(OP_FORMAT) + 1; k < OP_SPACE; k++) send_op(mk(OP_W'(k), NB - 1));
    send_op(mk(OP_FORMAT, 0));
    send_op(mk(OP_ALLOC_NEXT, 0));
    send_op(mk(OP_CLEAR, 0));
    send_op(mk(OP_ALLOC, NB - 1));
    send_op(mk(OP_FIND_NEXT, 0));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_BLOCK_COUNT, bc_plan[ph]);
      write_reg(REG_RESERVED_BLOCKS, rsv_plan[ph]);
      mode = ph % 4;
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 20 && (ph == 0 || ph == 6)) hold_kick++;
        send_op(make_request());
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (50) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
